/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Implication checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* rtl/locc_pkg.sv */
// Shared constants and types for the lock order cycle checker.
package locc_pkg;
    localparam int EdgeCapacity   = 512;
    localparam int HeldPerContext = 16;
    localparam int ContextCount   = 16;

    localparam int EdgeIdxW  = $clog2(EdgeCapacity);
    localparam int EdgeCntW  = $clog2(EdgeCapacity + 1);
    localparam int HeldIdxW  = $clog2(HeldPerContext);
    localparam int HeldCntW  = $clog2(HeldPerContext + 1);
    localparam int CtxW      = 4;
    localparam int CtxIdxW   = (ContextCount > 1) ? $clog2(ContextCount) : 1;
    localparam int HeldAddrW = CtxIdxW + HeldIdxW;
    localparam int HeldDepth = ContextCount * HeldPerContext;
    localparam int PathDepth = HeldPerContext + 1;
    localparam int PathIdxW  = $clog2(PathDepth);
    localparam int ClassW    = 32;
    localparam int TotalW    = 10;

    localparam logic CmdAcquire = 1'b0;
    localparam logic CmdRelease = 1'b1;

    typedef struct packed {
        logic                granted;
        logic [ClassW-1:0]   conflict_class;
        logic                held_list_full;
        logic                edge_store_full;
        logic                release_matched;
        logic [TotalW-1:0]   edge_total;
    } result_t;

    // search request and reply between sequencer and search engine
    typedef struct packed {
        logic              start;
        logic [ClassW-1:0] src_class;
        logic [ClassW-1:0] goal_class;
    } search_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } search_rsp_t;
endpackage

/* rtl/locc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module locc_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/locc_search.sv */
// Depth-first search over the edge memory with a bounded path stack.
module locc_search (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  locc_pkg::search_req_t             req,
    output locc_pkg::search_rsp_t             rsp,
    input  logic [locc_pkg::EdgeCntW-1:0]     edge_count,
    output logic [locc_pkg::EdgeIdxW-1:0]     edge_raddr,
    input  logic [2*locc_pkg::ClassW-1:0]     edge_rdata
);
    typedef enum logic [2:0] {S_IDLE, S_STEP, S_WAIT, S_CHECK, S_SCAN} state_t;

    localparam int PD = locc_pkg::PathDepth;
    localparam int PW = locc_pkg::PathIdxW;
    localparam int CW = locc_pkg::ClassW;

    state_t state_reg;
    logic [CW-1:0] goal_reg;
    logic [PW-1:0] depth_reg;
    logic [PW-1:0] scan_reg;
    logic [CW-1:0] tgt_reg;
    logic          onpath_reg;
    logic [locc_pkg::EdgeCntW-1:0] cur_reg;
    logic [locc_pkg::EdgeCntW-1:0] cur_next;
    logic [CW-1:0] node_rd;
    logic [CW-1:0] scan_rd;
    logic          node_we;
    logic [PW-1:0] node_waddr;
    logic [CW-1:0] node_wdata;
    logic          cur_we;
    logic [PW-1:0] cur_waddr;
    logic [locc_pkg::EdgeCntW-1:0] cur_wdata;
    logic [locc_pkg::EdgeCntW-1:0] cur_rd;
    logic [PW-1:0] node_raddr;
    logic [PW-1:0] cur_raddr;
    logic [CW-1:0] node_at_depth_reg;
    logic          scan_valid_reg;
    logic [PW-1:0] scan_cmp_idx_reg;

    // path stack: node classes, and edge cursors
    locc_ram #(.Width(CW), .Depth(PD)) u_node (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .raddr(node_raddr), .rdata(node_rd)
    );
    locc_ram #(.Width(locc_pkg::EdgeCntW), .Depth(PD)) u_cur (
        .aclk(aclk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
        .raddr(cur_raddr), .rdata(cur_rd)
    );
    assign scan_rd = node_rd;

    assign cur_next   = cur_reg - 1'b1;
    assign edge_raddr = cur_next[locc_pkg::EdgeIdxW-1:0];

    always_comb begin
        node_we = 1'b0; node_waddr = depth_reg; node_wdata = req.src_class;
        cur_we = 1'b0; cur_waddr = depth_reg; cur_wdata = edge_count;
        node_raddr = scan_reg;
        cur_raddr = depth_reg;
        unique case (state_reg)
            S_IDLE: begin
                node_waddr = '0;
                cur_waddr  = '0;
                if (req.start && req.src_class != req.goal_class) begin
                    node_we = 1'b1;
                    cur_we  = 1'b1;
                end
            end
            S_STEP: begin
                if (cur_reg != '0) begin
                    cur_we = 1'b1;
                    cur_wdata = cur_next;
                end else begin
                    // pop: fetch node and cursor of the level below
                    node_raddr = depth_reg - 1'b1;
                    cur_raddr  = depth_reg - 1'b1;
                end
            end
            S_SCAN: begin
                if (scan_reg == depth_reg && !onpath_reg && !(scan_reg == PW'(PD-1))
                    && tgt_reg != goal_reg) begin
                    node_we = 1'b1; node_waddr = depth_reg + 1'b1; node_wdata = tgt_reg;
                    cur_we = 1'b1; cur_waddr = depth_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rsp <= '0;
        end else begin
            rsp <= '0;
            unique case (state_reg)
                S_IDLE: begin
                    if (req.start) begin
                        goal_reg <= req.goal_class;
                        node_at_depth_reg <= req.src_class;
                        depth_reg <= '0;
                        cur_reg <= edge_count;
                        if (req.src_class == req.goal_class) begin
                            rsp <= '{done: 1'b1, hit: 1'b1};
                        end else begin
                            state_reg <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    if (cur_reg == '0) begin
                        if (depth_reg == '0) begin
                            rsp <= '{done: 1'b1, hit: 1'b0};
                            state_reg <= S_IDLE;
                        end else begin
                            depth_reg <= depth_reg - 1'b1;
                            scan_reg <= depth_reg - 1'b1;
                            state_reg <= S_WAIT;
                        end
                    end else begin
                        cur_reg <= cur_next;
                        state_reg <= S_CHECK;
                    end
                end
                S_WAIT: begin
                    // reload cursor and node of the popped level
                    cur_reg <= cur_rd;
                    node_at_depth_reg <= node_rd;
                    state_reg <= S_STEP;
                end
                S_CHECK: begin
                    if (edge_rdata[CW-1:0] != node_at_depth_reg) begin
                        state_reg <= S_STEP;
                    end else begin
                        tgt_reg <= edge_rdata[2*CW-1:CW];
                        scan_reg <= '0;
                        onpath_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // node_rd holds entry scan_cmp_idx_reg: compare one level a cycle
                    if (scan_rd == tgt_reg && scan_valid_reg) begin
                        onpath_reg <= 1'b1;
                    end
                    if (scan_valid_reg && scan_cmp_idx_reg == depth_reg) begin
                        if (onpath_reg || scan_rd == tgt_reg) begin
                            state_reg <= S_STEP;
                        end else if (depth_reg == PW'(PD-1) || tgt_reg == goal_reg) begin
                            rsp <= '{done: 1'b1, hit: 1'b1};
                            state_reg <= S_IDLE;
                        end else begin
                            depth_reg <= depth_reg + 1'b1;
                            node_at_depth_reg <= tgt_reg;
                            cur_reg <= edge_count;
                            state_reg <= S_STEP;
                        end
                    end
                    if (scan_reg != depth_reg) begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // compare pipeline for the path scan: read issued at scan_reg, data next cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_valid_reg <= 1'b0;
        end else begin
            scan_valid_reg <= (state_reg == S_SCAN) && !(scan_valid_reg
                && scan_cmp_idx_reg == depth_reg);
            scan_cmp_idx_reg <= scan_reg;
        end
    end
endmodule

/* rtl/lock_order_cycle_checker.sv */
// Top level of the lock order cycle checker: sequencer, edge and held memories.
// Usage:
//   s_axis_* carries one command word per lock operation:
//     tdata = {class_id[31:0], context_id[3:0], command} packed from bit 0,
//     zero filled to 40 bits. Acquire is command 0, release command 1.
//   m_axis_* returns one result word per command:
//     tdata = {edge_total, release_matched, edge_store_full,
//              held_list_full, conflict_class, granted} from bit 0.
//   cfg_we/cfg_wdata write the enabled bit (reset 1). The user must write it
//   only while idle; the block itself does not enforce this.
// Sequencing:
//   One command at a time. Release: held entries are compared from the
//   newest; after a match the entries above it are shifted down. Acquire:
//   per held entry, the recorded edges are read for the duplicate check,
//   then a depth-first search runs; time grows with the edge count, as
//   both share the single edge memory read port.
// Reset: aresetn low clears counts, the edge total and the held counts;
//   the memories are not cleared, since only counted entries are read.
// Stall: the result sits in an output register; s_axis_tready stays low
//   until m_axis accepts it, so nothing is lost.
module lock_order_cycle_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[0], context_id[4:1], class_id[36:5]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // granted[0], conflict_class[32:1], held_list_full[33],
    // edge_store_full[34], release_matched[35], edge_total[45:36]
    output logic [47:0] m_axis_tdata
);
    localparam int CW  = locc_pkg::ClassW;
    localparam int HPC = locc_pkg::HeldPerContext;
    localparam int HIW = locc_pkg::HeldIdxW;
    localparam int HCW = locc_pkg::HeldCntW;
    localparam int ECW = locc_pkg::EdgeCntW;
    localparam int EIW = locc_pkg::EdgeIdxW;

    typedef enum logic [3:0] {
        T_IDLE, T_HRD, T_HWAIT, T_PRESENT, T_PWAIT, T_PCHK, T_SEARCH,
        T_PUSH, T_RRD, T_RWAIT, T_RCHK, T_SHIFT, T_SWAIT, T_DONE
    } state_t;

    state_t state_reg;
    logic enabled_reg;
    logic [ECW-1:0] edge_count_reg;
    logic [HCW-1:0] held_cnt_reg [locc_pkg::ContextCount];

    logic [locc_pkg::CtxIdxW-1:0] ctx_reg;
    logic [CW-1:0] cls_reg;
    logic [HCW-1:0] n_reg;
    logic [HCW-1:0] i_reg;
    logic [CW-1:0] h_reg;
    logic [ECW-1:0] e_reg;
    logic          efull_reg;
    locc_pkg::result_t res_reg;
    logic          out_valid_reg;

    // held row memory
    logic                          held_we;
    logic [locc_pkg::HeldAddrW-1:0] held_waddr, held_raddr;
    logic [CW-1:0]                 held_wdata, held_rd;
    locc_ram #(.Width(CW), .Depth(locc_pkg::HeldDepth)) u_held (
        .aclk(aclk), .we(held_we), .waddr(held_waddr), .wdata(held_wdata),
        .raddr(held_raddr), .rdata(held_rd)
    );

    // edge memory: {target, source}
    logic           edge_we;
    logic [EIW-1:0] edge_raddr, srch_raddr;
    logic [2*CW-1:0] edge_rd;
    locc_ram #(.Width(2*CW), .Depth(locc_pkg::EdgeCapacity)) u_edge (
        .aclk(aclk), .we(edge_we), .waddr(edge_count_reg[EIW-1:0]),
        .wdata({cls_reg, h_reg}), .raddr(edge_raddr), .rdata(edge_rd)
    );

    locc_pkg::search_req_t sreq;
    locc_pkg::search_rsp_t srsp;
    locc_search u_search (
        .aclk(aclk), .aresetn(aresetn), .req(sreq), .rsp(srsp),
        .edge_count(edge_count_reg), .edge_raddr(srch_raddr), .edge_rdata(edge_rd)
    );

    logic [3:0]   in_ctx;
    logic         in_ok;
    logic [HCW-1:0] i_dec;
    assign in_ctx = s_axis_tdata[4:1];
    assign in_ok  = enabled_reg && (32'(in_ctx) < 32'(locc_pkg::ContextCount));
    assign i_dec  = i_reg - 1'b1;

    assign s_axis_tready = (state_reg == T_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b0, res_reg.edge_total, res_reg.release_matched,
                            res_reg.edge_store_full, res_reg.held_list_full,
                            res_reg.conflict_class, res_reg.granted};

    always_comb begin
        held_we = 1'b0;
        held_waddr = {ctx_reg, n_reg[HIW-1:0]};
        held_wdata = cls_reg;
        held_raddr = {ctx_reg, i_dec[HIW-1:0]};
        edge_we = 1'b0;
        edge_raddr = (state_reg == T_SEARCH) ? srch_raddr : e_reg[EIW-1:0];
        sreq = '{start: 1'b0, src_class: cls_reg, goal_class: h_reg};
        unique case (state_reg)
            T_PCHK: begin
                if (e_reg == edge_count_reg) begin
                    sreq.start = 1'b1;
                end
            end
            T_SEARCH: begin
                if (srsp.done && !srsp.hit && edge_count_reg != ECW'(locc_pkg::EdgeCapacity))
                begin
                    edge_we = 1'b1;
                end
            end
            T_PUSH: begin
                held_we = n_reg != HCW'(HPC);
            end
            T_RRD, T_RWAIT, T_RCHK: ;
            T_SHIFT: held_raddr = {ctx_reg, i_reg[HIW-1:0] + 1'b1};
            T_SWAIT: begin
                held_we = 1'b1;
                held_waddr = {ctx_reg, i_reg[HIW-1:0]};
                held_wdata = held_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            enabled_reg <= 1'b1;
            edge_count_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < locc_pkg::ContextCount; k++) begin
                held_cnt_reg[k] <= '0;
            end
        end else begin
            if (cfg_we) begin
                enabled_reg <= cfg_wdata;
            end
            if (out_valid_reg && m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        ctx_reg <= in_ctx[locc_pkg::CtxIdxW-1:0];
                        cls_reg <= s_axis_tdata[36:5];
                        n_reg <= held_cnt_reg[in_ctx[locc_pkg::CtxIdxW-1:0]];
                        i_reg <= held_cnt_reg[in_ctx[locc_pkg::CtxIdxW-1:0]];
                        efull_reg <= 1'b0;
                        res_reg <= locc_pkg::result_t'{granted: 1'b1, default: '0};
                        if (!in_ok) begin
                            state_reg <= T_DONE;
                        end else if (s_axis_tdata[0] == locc_pkg::CmdAcquire) begin
                            state_reg <= T_HRD;
                        end else begin
                            state_reg <= T_RRD;
                        end
                    end
                end
                T_HRD: begin
                    state_reg <= (i_reg == '0) ? T_PUSH : T_HWAIT;
                end
                T_HWAIT: begin
                    h_reg <= held_rd;
                    i_reg <= i_dec;
                    e_reg <= '0;
                    state_reg <= T_PRESENT;
                end
                T_PRESENT: state_reg <= T_PWAIT; // read of edge e_reg in flight
                T_PWAIT: state_reg <= T_PCHK;
                T_PCHK: begin
                    if (e_reg == edge_count_reg) begin
                        state_reg <= T_SEARCH;
                    end else if (edge_rd == {cls_reg, h_reg}) begin
                        state_reg <= T_HRD;
                    end else begin
                        e_reg <= e_reg + 1'b1;
                        state_reg <= T_PRESENT;
                    end
                end
                T_SEARCH: begin
                    if (srsp.done) begin
                        if (srsp.hit) begin
                            res_reg.granted <= 1'b0;
                            res_reg.conflict_class <= h_reg;
                            res_reg.edge_store_full <= efull_reg;
                            state_reg <= T_DONE;
                        end else begin
                            if (edge_count_reg != ECW'(locc_pkg::EdgeCapacity)) begin
                                edge_count_reg <= edge_count_reg + 1'b1;
                            end else begin
                                efull_reg <= 1'b1;
                            end
                            state_reg <= T_HRD;
                        end
                    end
                end
                T_PUSH: begin
                    res_reg.edge_store_full <= efull_reg;
                    if (n_reg != HCW'(HPC)) begin
                        held_cnt_reg[ctx_reg] <= n_reg + 1'b1;
                    end else begin
                        res_reg.held_list_full <= 1'b1;
                    end
                    state_reg <= T_DONE;
                end
                T_RRD: state_reg <= (i_reg == '0) ? T_DONE : T_RWAIT;
                T_RWAIT: state_reg <= T_RCHK;
                T_RCHK: begin
                    if (held_rd == cls_reg) begin
                        res_reg.release_matched <= 1'b1;
                        held_cnt_reg[ctx_reg] <= n_reg - 1'b1;
                        i_reg <= i_dec;
                        state_reg <= T_SHIFT;
                    end else begin
                        i_reg <= i_dec;
                        state_reg <= T_RRD;
                    end
                end
                T_SHIFT: begin
                    state_reg <= (i_reg + 1'b1 >= n_reg) ? T_DONE : T_SWAIT;
                end
                T_SWAIT: begin
                    i_reg <= i_reg + 1'b1;
                    state_reg <= T_SHIFT;
                end
                T_DONE: begin
                    res_reg.edge_total <= locc_pkg::TotalW'(edge_count_reg);
                    out_valid_reg <= 1'b1;
                    state_reg <= T_IDLE;
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end
endmodule

/* rtl/locc_checker.sv */
// Port-level checker for the lock order cycle checker, bound to the top.
`include "assert_macros.svh"
module locc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped under stall")
    `ASSERT_CLK(a_one_at_time, aclk, aresetn, m_axis_tvalid |-> !s_axis_tready, "input taken while result pending")
    `ASSERT_CLK(a_deny_flags, aclk, aresetn, m_axis_tvalid && !m_axis_tdata[0] |-> !m_axis_tdata[33] && !m_axis_tdata[35], "denied result with held or release flag")
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_axis_tvalid, "result valid after reset")
endmodule

bind lock_order_cycle_checker locc_checker u_locc_checker (.*);
